// ===== src/pss_pkg.sv =====
// Package for the pen stroke splitter: sizes, table depth and controller states.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
package pss_pkg;

    localparam int COORD_W = 12;
    localparam int CNT_W = 13;
    localparam int DIV_STEPS = 12;
    localparam int DIV_CNT_W = 4;
    localparam int DIVR_W = 7;
    localparam int TANS_W = 6;
    localparam logic [CNT_W-1:0] TABLE_DEPTH = 13'd4096;
    localparam logic [DIVR_W-1:0] SPLIT_LIMIT = 7'd127;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TGO,
        S_TWAIT,
        S_QGO,
        S_QWAIT,
        S_STEP,
        S_ADJ,
        S_EMIT
    } t_state;

endpackage

// ===== src/pss_if.sv =====
// Handshake channels of the pen stroke splitter: segment input and piece output.
// Depends on pss_pkg for field widths.
`timescale 1ns / 1ps
interface pss_seg_if import pss_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [3:0]         width_begin;
    logic [3:0]         width_finish;
    logic [7:0]         pen;

    modport source (output valid, start_x, start_y, end_x, end_y, width_begin,
                    width_finish, pen, input ready);
    modport sink (input valid, start_x, start_y, end_x, end_y, width_begin,
                  width_finish, pen, output ready);
endinterface

interface pss_piece_if import pss_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] slot;
    logic [COORD_W-1:0] piece_x;
    logic [COORD_W-1:0] piece_y;
    logic signed [8:0]  piece_dx;
    logic signed [8:0]  piece_dy;
    logic [3:0]         piece_width_begin;
    logic [3:0]         piece_width_finish;
    logic [7:0]         piece_pen;
    logic               last;

    modport source (output valid, slot, piece_x, piece_y, piece_dx, piece_dy,
                    piece_width_begin, piece_width_finish, piece_pen, last,
                    input ready);
    modport sink (input valid, slot, piece_x, piece_y, piece_dx, piece_dy,
                  piece_width_begin, piece_width_finish, piece_pen, last,
                  output ready);
endinterface

// ===== src/pss_div.sv =====
// Bit-serial restoring divider: 12-bit unsigned dividend by a 7-bit divisor.
// Depends on pss_pkg; one quotient bit is produced per cycle.
`timescale 1ns / 1ps
module pss_div
    import pss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [COORD_W-1:0] i_dividend,
    input  logic [DIVR_W-1:0]  i_divisor,
    output logic               o_done,
    output logic [COORD_W-1:0] o_quot
);

    logic                 r_busy, n_busy;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DIVR_W-1:0]    r_rem, n_rem;
    logic [COORD_W-1:0]   r_quo, n_quo;
    logic [DIVR_W-1:0]    r_dvs, n_dvs;
    logic [DIVR_W:0]      w_trial;

    // One restoring step per cycle; the dividend shifts out as quotient bits shift in.
    // After the last step the quotient is held for one done cycle.
    always_comb begin
        n_busy = r_busy;
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_quo = r_quo;
        n_dvs = r_dvs;
        w_trial = {r_rem, r_quo[COORD_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt = '0;
            n_rem = '0;
            n_quo = i_dividend;
            n_dvs = i_divisor;
        end else if (r_busy) begin
            if (r_cnt == DIV_CNT_W'(DIV_STEPS)) begin
                n_busy = 1'b0;
            end else begin
                if (w_trial >= {1'b0, r_dvs}) begin
                    n_rem = DIVR_W'(w_trial - {1'b0, r_dvs});
                    n_quo = {r_quo[COORD_W-2:0], 1'b1};
                end else begin
                    n_rem = w_trial[DIVR_W-1:0];
                    n_quo = {r_quo[COORD_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done = r_busy && (r_cnt == DIV_CNT_W'(DIV_STEPS));
    assign o_quot = r_quo;

endmodule

// ===== src/pen_stroke_splitter.sv =====
// Pen stroke splitter: top level with the piece sequencer and output register.
// Depends on pss_pkg, the pss_seg_if / pss_piece_if channels and pss_div.
//
// Usage: one segment item enters on i_seg (valid/ready); it leaves as one or
// more piece items on o_piece, each tagged with its table slot, the final one
// with last set. The block works on one segment at a time and raises ready only
// when idle. A short segment (both extents within 127) gives a single piece.
// A long segment first runs the serial dividers twice, once for the piece count
// and once for the x and y steps, then per piece passes a step state, repeats
// width-correction steps until the width fraction is in range (skipped for the
// final piece) and emits it. A segment that finds the table full gives no piece
// and clears the slot counter.
// Reset clears the slot counter, the sequencer and the output valid flag.
// A stalled receiver holds the piece in the output register; the sequencer
// waits for it and nothing is lost.
`timescale 1ns / 1ps
module pen_stroke_splitter
    import pss_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    pss_seg_if.sink       i_seg,
    pss_piece_if.source   o_piece
);

    t_state r_state, n_state;

    // Segment registers
    logic [COORD_W-1:0] r_sx, r_sy, r_ex, r_ey, r_px, r_py;
    logic [COORD_W-1:0] n_sx, n_sy, n_ex, n_ey, n_px, n_py;
    logic [3:0]         r_w0, r_w1, n_w0, n_w1;
    logic [7:0]         r_pen, n_pen;
    logic [COORD_W-1:0] r_adx, r_ady, n_adx, n_ady;
    logic               r_sgx, r_sgy, n_sgx, n_sgy;
    logic [TANS_W-1:0]  r_tans, n_tans, r_i, n_i;
    logic signed [5:0]  r_wq, r_wqp, n_wq, n_wqp;
    logic signed [6:0]  r_wr, n_wr;
    logic [CNT_W-1:0]   r_wc, n_wc;

    // Output register
    logic               r_ov, n_ov;
    logic [COORD_W-1:0] r_oslot, r_ox, r_oy, n_oslot, n_ox, n_oy;
    logic [8:0]         r_odx, r_ody, n_odx, n_ody;
    logic [3:0]         r_owb, r_owf, n_owb, n_owf;
    logic [7:0]         r_open, n_open;
    logic               r_olast, n_olast;

    // Divider hookup and helpers
    logic               w_dstart;
    logic [COORD_W-1:0] w_ddx, w_ddy;
    logic [DIVR_W-1:0]  w_dvs;
    logic               w_donex, w_doney;
    logic [COORD_W-1:0] w_quox, w_quoy;
    logic               w_accept, w_free, w_final, w_full;
    logic [COORD_W:0]   w_dx, w_dy, w_qx, w_qy;
    logic [COORD_W-1:0] w_max;
    logic               w_short;

    pss_div u_divx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dstart),
        .i_dividend (w_ddx),
        .i_divisor  (w_dvs),
        .o_done     (w_donex),
        .o_quot     (w_quox)
    );

    pss_div u_divy (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dstart),
        .i_dividend (w_ddy),
        .i_divisor  (w_dvs),
        .o_done     (w_doney),
        .o_quot     (w_quoy)
    );

    // Entry differences and split test
    assign w_accept = i_seg.valid && i_seg.ready;
    assign w_dx = {1'b0, i_seg.end_x} - {1'b0, i_seg.start_x};
    assign w_dy = {1'b0, i_seg.end_y} - {1'b0, i_seg.start_y};
    assign w_short = (r_adx <= COORD_W'(SPLIT_LIMIT)) && (r_ady <= COORD_W'(SPLIT_LIMIT));
    assign w_max = (n_adx > n_ady) ? n_adx : n_ady;

    // Signed steps from the divider magnitudes
    assign w_qx = r_sgx ? -{1'b0, w_quox} : {1'b0, w_quox};
    assign w_qy = r_sgy ? -{1'b0, w_quoy} : {1'b0, w_quoy};

    assign w_free = !r_ov || o_piece.ready;
    assign w_final = (r_i == r_tans - 1'b1);
    assign w_full = (r_wc + 1'b1) >= TABLE_DEPTH;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && r_wc < TABLE_DEPTH) begin
                    n_state = S_TGO;
                end
            end
            S_TGO: begin
                n_state = w_short ? S_STEP : S_TWAIT;
            end
            S_TWAIT: begin
                if (w_donex) begin
                    n_state = S_QGO;
                end
            end
            S_QGO: begin
                n_state = S_QWAIT;
            end
            S_QWAIT: begin
                if (w_donex && w_doney) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                n_state = w_final ? S_EMIT : S_ADJ;
            end
            S_ADJ: begin
                if (r_wr >= 0 && r_wr < $signed({1'b0, r_tans})) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_free) begin
                    n_state = (w_final || w_full) ? S_IDLE : S_STEP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Handshake and divider control
    always_comb begin
        i_seg.ready = 1'b0;
        w_dstart = 1'b0;
        w_ddx = r_adx;
        w_ddy = r_ady;
        w_dvs = DIVR_W'(r_tans);
        case (r_state)
            S_IDLE: i_seg.ready = 1'b1;
            S_TGO: begin
                w_dstart = !w_short;
                w_ddx = (r_adx > r_ady) ? r_adx : r_ady;
                w_dvs = SPLIT_LIMIT;
            end
            S_QGO: w_dstart = 1'b1;
            default: ;
        endcase
    end

    // Datapath
    always_comb begin
        n_sx = r_sx; n_sy = r_sy; n_ex = r_ex; n_ey = r_ey;
        n_px = r_px; n_py = r_py; n_w0 = r_w0; n_w1 = r_w1; n_pen = r_pen;
        n_adx = r_adx; n_ady = r_ady; n_sgx = r_sgx; n_sgy = r_sgy;
        n_tans = r_tans; n_i = r_i; n_wq = r_wq; n_wqp = r_wqp; n_wr = r_wr;
        n_wc = r_wc;
        n_ov = r_ov && !o_piece.ready;
        n_oslot = r_oslot; n_ox = r_ox; n_oy = r_oy; n_odx = r_odx; n_ody = r_ody;
        n_owb = r_owb; n_owf = r_owf; n_open = r_open; n_olast = r_olast;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (r_wc >= TABLE_DEPTH) begin
                        n_wc = '0;
                    end
                    n_sx = i_seg.start_x; n_sy = i_seg.start_y;
                    n_ex = i_seg.end_x; n_ey = i_seg.end_y;
                    n_px = i_seg.start_x; n_py = i_seg.start_y;
                    n_w0 = i_seg.width_begin; n_w1 = i_seg.width_finish;
                    n_pen = i_seg.pen;
                    n_sgx = w_dx[COORD_W];
                    n_sgy = w_dy[COORD_W];
                    n_adx = w_dx[COORD_W] ? COORD_W'(-w_dx) : w_dx[COORD_W-1:0];
                    n_ady = w_dy[COORD_W] ? COORD_W'(-w_dy) : w_dy[COORD_W-1:0];
                    n_tans = TANS_W'(1);
                    n_i = '0; n_wq = '0; n_wqp = '0; n_wr = '0;
                end
            end
            S_TWAIT: begin
                // The piece count is ready before the step division starts.
                if (w_donex) begin
                    n_tans = TANS_W'(w_quox + 1'b1);
                end
            end
            S_STEP: begin
                n_wr = r_wr + 7'($signed({1'b0, r_w1}) - $signed({1'b0, r_w0}));
            end
            S_ADJ: begin
                // One floor correction of the width fraction per cycle.
                if (r_wr >= $signed({1'b0, r_tans})) begin
                    n_wr = r_wr - $signed({1'b0, r_tans});
                    n_wq = r_wq + 6'sd1;
                end else if (r_wr < 0) begin
                    n_wr = r_wr + $signed({1'b0, r_tans});
                    n_wq = r_wq - 6'sd1;
                end
            end
            S_EMIT: begin
                if (w_free) begin
                    n_ov = 1'b1;
                    n_oslot = r_wc[COORD_W-1:0];
                    n_ox = r_px;
                    n_oy = r_py;
                    n_odx = w_final ? 9'(r_ex - r_px) : w_qx[8:0];
                    n_ody = w_final ? 9'(r_ey - r_py) : w_qy[8:0];
                    n_owb = 4'(6'($signed({2'b0, r_w0}) + r_wqp));
                    n_owf = w_final ? r_w1 : 4'(6'($signed({2'b0, r_w0}) + r_wq));
                    n_open = r_pen;
                    n_olast = w_final || w_full;
                    n_wc = r_wc + 1'b1;
                    n_px = r_px + w_qx[COORD_W-1:0];
                    n_py = r_py + w_qy[COORD_W-1:0];
                    n_wqp = r_wq;
                    n_i = r_i + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wc <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wc <= n_wc;
            r_ov <= n_ov;
        end
        r_sx <= n_sx; r_sy <= n_sy; r_ex <= n_ex; r_ey <= n_ey;
        r_px <= n_px; r_py <= n_py; r_w0 <= n_w0; r_w1 <= n_w1; r_pen <= n_pen;
        r_adx <= n_adx; r_ady <= n_ady; r_sgx <= n_sgx; r_sgy <= n_sgy;
        r_tans <= n_tans; r_i <= n_i; r_wq <= n_wq; r_wqp <= n_wqp; r_wr <= n_wr;
        r_oslot <= n_oslot; r_ox <= n_ox; r_oy <= n_oy; r_odx <= n_odx;
        r_ody <= n_ody; r_owb <= n_owb; r_owf <= n_owf; r_open <= n_open;
        r_olast <= n_olast;
    end

    // Output channel
    assign o_piece.valid = r_ov;
    assign o_piece.slot = r_oslot;
    assign o_piece.piece_x = r_ox;
    assign o_piece.piece_y = r_oy;
    assign o_piece.piece_dx = r_odx;
    assign o_piece.piece_dy = r_ody;
    assign o_piece.piece_width_begin = r_owb;
    assign o_piece.piece_width_finish = r_owf;
    assign o_piece.piece_pen = r_open;
    assign o_piece.last = r_olast;

    // The start point, w_max and w_doney are unused and only folded into w_unused.
    logic w_unused;
    assign w_unused = ^{r_sx, r_sy, w_max, w_doney};

endmodule

// ===== tb/sv/tb_pen_stroke_splitter.sv =====
// Self-checking testbench for pen_stroke_splitter: drives segment items and checks
// every piece item against an in-bench prediction of the split. Depends on pss_pkg,
// the pss_seg_if / pss_piece_if channels and the pen_stroke_splitter RTL.
`timescale 1ns / 1ps
module tb_pen_stroke_splitter import pss_pkg::*; ();

    localparam int DEPTH = 4096;
    localparam int SPAN = 127;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD = 400;
    localparam int HOLD_AFTER = 60;

    typedef struct {
        logic [11:0] sx, sy, ex, ey;
        logic [3:0]  wb, wf;
        logic [7:0]  pen;
        int          phase;
        bit          drain;
    } segment_t;

    typedef struct {
        logic [11:0]       slot, x, y;
        logic signed [8:0] dx, dy;
        logic [3:0]        wb, wf;
        logic [7:0]        pen;
        logic              last;
    } piece_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pss_seg_if   seg ();
    pss_piece_if pc ();

    pen_stroke_splitter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg.sink),
        .o_piece (pc.source)
    );

    segment_t    pending[$];
    piece_t      expected_pieces[$];
    logic [12:0] slot_count = '0;
    int          errors = 0;
    int          cycles = 0;
    int          segs_taken = 0;
    int          cur_phase = 0;
    int          hold_left = 0;
    bit          long_hold_done = 1'b0;

    always #2 i_clk = ~i_clk;

    // Floor division, rounding toward minus infinity.
    function automatic int floor_div(int n, int d);
        int q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    // Splits one segment into pieces and advances the slot counter, or clears it when the table is full.
    function automatic void split_segment(input segment_t s, ref logic [12:0] cnt,
                                          ref piece_t out[$]);
        int sx, sy, ex, ey, w0, w1, dx, dy, dw, adx, ady, tans, qx, qy, px, py;
        bit full, fin;
        piece_t p;
        sx = int'(s.sx); sy = int'(s.sy); ex = int'(s.ex); ey = int'(s.ey);
        w0 = int'(s.wb); w1 = int'(s.wf);
        dx = ex - sx; dy = ey - sy; dw = w1 - w0;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        p.pen = s.pen;
        if (cnt >= DEPTH) begin
            cnt = '0;
            return;
        end
        if (adx <= SPAN && ady <= SPAN) begin
            p.slot = cnt[11:0]; p.x = s.sx; p.y = s.sy;
            p.dx = dx[8:0]; p.dy = dy[8:0]; p.wb = s.wb; p.wf = s.wf; p.last = 1'b1;
            out.push_back(p);
            cnt++;
            return;
        end
        tans = (adx > ady ? adx : ady) / SPAN + 1;
        qx = dx / tans;
        qy = dy / tans;
        for (int i = 0; i < tans; i++) begin
            fin = (i == tans - 1);
            px = sx + qx * i;
            py = sy + qy * i;
            p.slot = cnt[11:0];
            p.x = px[11:0];
            p.y = py[11:0];
            p.wb = 4'(w0 + floor_div(dw * i, tans));
            if (fin) begin
                p.dx = 9'(ex - px);
                p.dy = 9'(ey - py);
                p.wf = s.wf;
            end else begin
                p.dx = qx[8:0];
                p.dy = qy[8:0];
                p.wf = 4'(w0 + floor_div(dw * (i + 1), tans));
            end
            full = (cnt + 1 >= DEPTH);
            p.last = fin || full;
            out.push_back(p);
            cnt++;
            if (full) break;
        end
    endfunction

    // Stimulus: directed segments, random segments over three idling phases,
    // a run that fills the table, then a short tail after the wrap.
    initial begin : stimulus
        logic [12:0] plan_count;
        piece_t scratch[$];
        int remaining;
        plan_count = '0;
        seg.valid = 1'b0;
        seg.start_x = '0; seg.start_y = '0; seg.end_x = '0; seg.end_y = '0;
        seg.width_begin = '0; seg.width_finish = '0; seg.pen = '0;
        pc.ready = 1'b0;

        // Directed: short, boundary, longest and width extremes.
        add_seg(0, 0, 0, 0, 0, 0, 0, 0, plan_count, scratch);
        add_seg(100, 100, 227, 100, 3, 9, 255, 0, plan_count, scratch);
        add_seg(500, 500, 373, 627, 15, 0, 1, 0, plan_count, scratch);
        add_seg(100, 100, 228, 100, 0, 15, 2, 0, plan_count, scratch);
        add_seg(100, 100, 100, 228, 15, 0, 3, 0, plan_count, scratch);
        add_seg(0, 0, 4095, 4095, 0, 15, 128, 0, plan_count, scratch);
        add_seg(4095, 4095, 0, 0, 15, 0, 127, 0, plan_count, scratch);
        add_seg(0, 4095, 4095, 0, 7, 8, 64, 0, plan_count, scratch);
        add_seg(4095, 0, 0, 4095, 8, 7, 32, 0, plan_count, scratch);
        add_seg(2000, 10, 1000, 15, 5, 5, 16, 0, plan_count, scratch);
        add_seg(10, 3000, 14, 1999, 1, 14, 8, 0, plan_count, scratch);
        add_seg(1234, 777, 1361, 650, 12, 3, 4, 0, plan_count, scratch);
        add_seg(4095, 4095, 4095, 4095, 15, 15, 255, 0, plan_count, scratch);
        add_seg(3000, 1000, 2745, 1381, 9, 2, 90, 0, plan_count, scratch);

        for (int k = 0; k < 60; k++) begin
            rand_seg(k < 20 ? 0 : (k < 40 ? 1 : 2), plan_count, scratch);
            if (k == 50) pending[$].drain = 1'b1;
        end

        // Fill the table, ending with a segment that overflows it partway.
        while (plan_count < DEPTH) begin
            remaining = DEPTH - plan_count;
            if (remaining >= 33)
                add_seg(0, $urandom_range(0, 4095), 4095, $urandom_range(0, 4095),
                        $urandom_range(0, 15), $urandom_range(0, 15),
                        $urandom_range(0, 255), 2, plan_count, scratch);
            else
                add_seg(4095, 5, 0, 4000, $urandom_range(0, 15), $urandom_range(0, 15),
                        $urandom_range(0, 255), 2, plan_count, scratch);
        end
        // Segment that finds the table full, then fresh segments from slot 0.
        for (int k = 0; k < 8; k++) rand_seg(2, plan_count, scratch);

        wait (pending.size() == 0 && expected_pieces.size() == 0);
        repeat (60) @(posedge i_clk);
        if (errors == 0)
            $display("pen_stroke_splitter: match");
        else
            $display("pen_stroke_splitter: mismatch");
        $finish;
    end

    task automatic add_seg(input int sx, sy, ex, ey, wb, wf, pen, phase,
                           ref logic [12:0] cnt, ref piece_t scratch[$]);
        segment_t s;
        s.sx = 12'(sx); s.sy = 12'(sy); s.ex = 12'(ex); s.ey = 12'(ey);
        s.wb = 4'(wb); s.wf = 4'(wf); s.pen = 8'(pen); s.phase = phase; s.drain = 1'b0;
        pending.push_back(s);
        split_segment(s, cnt, scratch);
        scratch.delete();
    endtask

    // Random segment: short, anywhere, or spanning nearly the full range.
    task automatic rand_seg(input int phase, ref logic [12:0] cnt, ref piece_t scratch[$]);
        int sx, sy, ex, ey, tmp, mode;
        mode = $urandom_range(0, 9);
        sx = $urandom_range(0, 4095);
        sy = $urandom_range(0, 4095);
        if (mode < 3) begin
            ex = sx + $urandom_range(0, 254) - 127;
            ey = sy + $urandom_range(0, 254) - 127;
            ex = ex < 0 ? 0 : (ex > 4095 ? 4095 : ex);
            ey = ey < 0 ? 0 : (ey > 4095 ? 4095 : ey);
        end else if (mode < 7) begin
            ex = $urandom_range(0, 4095);
            ey = $urandom_range(0, 4095);
        end else begin
            sx = $urandom_range(0, 40);
            ex = $urandom_range(4055, 4095);
            ey = $urandom_range(0, 4095);
            if ($urandom_range(0, 1)) begin tmp = sx; sx = ex; ex = tmp; end
            if ($urandom_range(0, 1)) begin
                tmp = sx; sx = sy; sy = tmp;
                tmp = ex; ex = ey; ey = tmp;
            end
        end
        add_seg(sx, sy, ex, ey, $urandom_range(0, 15), $urandom_range(0, 15),
                $urandom_range(0, 255), phase, cnt, scratch);
    endtask

    // Clock counter, reset release and timeout.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == 5) i_rst_n <= 1'b1;
        if (cycles > CYCLE_LIMIT) begin
            $display("pen_stroke_splitter: mismatch");
            $finish;
        end
    end

    // Segment driver: holds an offered item until it is taken.
    always @(posedge i_clk) begin : seg_driver
        bit offer;
        int idle_pct;
        offer = 1'b0;
        idle_pct = cur_phase == 0 ? 30 : (cur_phase == 1 ? 46 : 0);
        if (!i_rst_n) begin
            seg.valid <= 1'b0;
        end else begin
            if (seg.valid && seg.ready) begin
                split_segment(pending[0], slot_count, expected_pieces);
                void'(pending.pop_front());
                segs_taken <= segs_taken + 1;
            end else if (seg.valid) begin
                offer = 1'b1;
            end
            if (!offer && pending.size() != 0
                && !(pending[0].drain && expected_pieces.size() != 0)
                && $urandom_range(0, 99) >= idle_pct)
                offer = 1'b1;
            if (offer) begin
                seg.start_x <= pending[0].sx;
                seg.start_y <= pending[0].sy;
                seg.end_x <= pending[0].ex;
                seg.end_y <= pending[0].ey;
                seg.width_begin <= pending[0].wb;
                seg.width_finish <= pending[0].wf;
                seg.pen <= pending[0].pen;
                cur_phase <= pending[0].phase;
            end
            seg.valid <= offer;
        end
    end

    // Piece receiver and checker, with one long hold-off to back up the block.
    always @(posedge i_clk) begin : piece_checker
        piece_t e, got;
        int idle_pct;
        idle_pct = cur_phase == 0 ? 46 : (cur_phase == 1 ? 30 : 0);
        if (!i_rst_n) begin
            pc.ready <= 1'b0;
        end else begin
            if (pc.valid && pc.ready) begin
                got.slot = pc.slot; got.x = pc.piece_x; got.y = pc.piece_y;
                got.dx = pc.piece_dx; got.dy = pc.piece_dy;
                got.wb = pc.piece_width_begin; got.wf = pc.piece_width_finish;
                got.pen = pc.piece_pen; got.last = pc.last;
                if (expected_pieces.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected piece, expected none, got %p", $realtime, got);
                end else begin
                    e = expected_pieces.pop_front();
                    if (got.slot !== e.slot || got.x !== e.x || got.y !== e.y
                        || got.dx !== e.dx || got.dy !== e.dy || got.wb !== e.wb
                        || got.wf !== e.wf || got.pen !== e.pen || got.last !== e.last) begin
                        errors++;
                        $display("%0t: piece differs, expected %p, got %p",
                                 $realtime, e, got);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                pc.ready <= 1'b0;
            end else if (!long_hold_done && segs_taken >= HOLD_AFTER) begin
                hold_left <= LONG_HOLD;
                long_hold_done <= 1'b1;
                pc.ready <= 1'b0;
            end else begin
                pc.ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

endmodule

// ===== sim.f =====
src/pss_pkg.sv
src/pss_if.sv
src/pss_div.sv
src/pen_stroke_splitter.sv
tb/sv/tb_pen_stroke_splitter.sv
